[src/nta_pkg.sv]
`default_nettype none
package nta_pkg;

   localparam int TableSlotsDefault = 32;
   localparam int MaxResults = 32;
   localparam int EvictCountWidth = 6;
   localparam logic [7:0] EvictedState = 8'd3;

   localparam logic [2:0] REQ_SENSOR    = 3'd0;
   localparam logic [2:0] REQ_HEARTBEAT = 3'd1;
   localparam logic [2:0] REQ_DISCOVERY = 3'd2;
   localparam logic [2:0] REQ_SWEEP     = 3'd3;
   localparam logic [2:0] REQ_READ      = 3'd4;

   localparam logic [3:0] ST_UPDATED = 4'd0;
   localparam logic [3:0] ST_ADDED   = 4'd1;
   localparam logic [3:0] ST_FULL    = 4'd2;
   localparam logic [3:0] ST_EVICTED = 4'd3;
   localparam logic [3:0] ST_NONE    = 4'd4;
   localparam logic [3:0] ST_EMPTY   = 4'd5;
   localparam logic [3:0] ST_ACTIVE  = 4'd6;
   localparam logic [3:0] ST_WARNING = 4'd7;
   localparam logic [3:0] ST_OFFLINE = 4'd8;

   localparam logic [1:0] REG_WARN    = 2'd0;
   localparam logic [1:0] REG_OFFLINE = 2'd1;
   localparam logic [1:0] REG_EVICT   = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] now_ms;
      logic [47:0] src_addr;
      logic [7:0]  gw_hops;
      logic signed [7:0] rssi;
      logic [7:0]  peer_num;
      logic [7:0]  self_state;
      logic [31:0] run_seconds;
      logic [4:0]  slot_index;
   } req_type_type;

   typedef struct packed {
      logic [3:0]  status_code;
      logic [4:0]  found_slot;
      logic [47:0] entry_mac;
      logic [31:0] entry_age_ms;
      logic [7:0]  entry_hops;
      logic signed [7:0] entry_rssi;
      logic [7:0]  entry_peers;
      logic [7:0]  entry_state;
      logic [31:0] entry_uptime;
      logic [15:0] entry_packets;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [47:0] mac;
      logic [31:0] seen_ms;
      logic [7:0]  hops;
      logic [7:0]  rssi;
      logic [7:0]  peers;
      logic [7:0]  state;
      logic [31:0] uptime;
      logic [15:0] packets;
   } entry_type;

endpackage
`default_nettype wire

[src/nta_cell.sv]
`default_nettype none
module nta_cell
   import nta_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      shift_en,
   input  wire entry_type entry_in,
   output      entry_type entry_out
);

   entry_type entry_ff;

   // Each cell holds one entry and takes its neighbour's entry on a shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule
`default_nettype wire

[src/node_table_with_aging_core.sv]
`default_nettype none
// Node table with aging: a table of known nodes keyed by 48-bit address.
// Requests enter on the req_ channel (valid/ready) and results leave on the
// rsp_ channel (valid/ready) as one item each; last_result marks the final
// item of a request. Age thresholds are written through the csr_ APB port.
// The entries live in a ring of cells that, during a request and when the
// output is not stalled, rotates by one slot per cycle past a single head
// position, where each slot is examined or updated. A report takes two
// full rotations (find the hit or the lowest free slot, then write it), or
// one if the table is full; a sweep or a slot read takes one rotation. The
// rotation length sets the rate. A sweep gives one item per evicted entry,
// at most 32, or one item saying that nothing was evicted. A new request is
// taken only when the previous one has finished. When the receiver stalls,
// the ring stops turning until the output register is free, so no item is
// lost. Reset clears every entry and sets the thresholds to their defaults.
module node_table_with_aging_core
   import nta_pkg::*;
#(
   parameter int TABLE_SLOTS = TableSlotsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire req_type_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   output      rsp_type      rsp_data,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output      logic [31:0]  csr_prdata,
   output      logic         csr_pready
);

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [IW-1:0] LastIdx = IW'(TABLE_SLOTS - 1);

   typedef enum logic [3:0] {
      FSM_IDLE  = 4'b0001,
      FSM_SCAN  = 4'b0010,
      FSM_APPLY = 4'b0100,
      FSM_FLUSH = 4'b1000
   } fsm_type;

   // Configuration registers.
   logic [31:0] warn_ff, offline_ff, evict_ff;
   logic        csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_ff    <= 32'd15000;
         offline_ff <= 32'd30000;
         evict_ff   <= 32'd60000;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_WARN:    warn_ff    <= csr_pwdata;
            REG_OFFLINE: offline_ff <= csr_pwdata;
            REG_EVICT:   evict_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WARN:    csr_prdata = warn_ff;
         REG_OFFLINE: csr_prdata = offline_ff;
         REG_EVICT:   csr_prdata = evict_ff;
         default:     csr_prdata = '0;
      endcase
   end

   // Control state.
   fsm_type                  fsm_ff, fsm_in;
   logic [IW-1:0]            cnt_ff, cnt_in;
   req_type_type             req_ff, req_in;
   logic                     hit_ff, hit_in, free_ff, free_in;
   logic [IW-1:0]            hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic                     pend_v_ff, pend_v_in;
   entry_type                pend_ff, pend_in;
   logic [IW-1:0]            pend_idx_ff, pend_idx_in;
   logic [EvictCountWidth-1:0] nev_ff, nev_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Ring of cells; cell 0 is the head.
   entry_type cell_q [TABLE_SLOTS];
   entry_type head_new;
   logic      shift_en;

   genvar g;
   generate
      for (g = 0; g < TABLE_SLOTS; g++) begin : g_cell
         entry_type nbr;
         if (g == TABLE_SLOTS - 1) begin : g_tail
            assign nbr = head_new;
         end else begin : g_mid
            assign nbr = cell_q[g+1];
         end
         nta_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .entry_in (nbr),
            .entry_out(cell_q[g])
         );
      end
   endgenerate

   function automatic rsp_type put_entry(input entry_type e, input logic [3:0] st,
                                         input logic [IW-1:0] idx,
                                         input logic [31:0] now, input logic last);
      rsp_type r;
      r.status_code   = st;
      r.found_slot    = 5'(idx);
      r.entry_mac     = e.mac;
      r.entry_age_ms  = now - e.seen_ms;
      r.entry_hops    = e.hops;
      r.entry_rssi    = e.rssi;
      r.entry_peers   = e.peers;
      r.entry_state   = e.state;
      r.entry_uptime  = e.uptime;
      r.entry_packets = e.packets;
      r.last_result   = last;
      return r;
   endfunction

   function automatic rsp_type put_blank(input logic [3:0] st, input logic [4:0] slot);
      rsp_type r;
      r             = '0;
      r.status_code = st;
      r.found_slot  = slot;
      r.last_result = 1'b1;
      return r;
   endfunction

   entry_type   head;
   logic        step_en;
   logic        mac_hit, is_last, evict_now;
   logic [31:0] head_age, pend_age;
   logic [IW-1:0] tgt;

   assign head     = cell_q[0];
   assign step_en  = !rsp_valid_ff || rsp_ready;
   assign is_last  = (cnt_ff == LastIdx);
   assign head_age = req_ff.now_ms - head.seen_ms;
   assign pend_age = req_ff.now_ms - pend_ff.seen_ms;
   assign mac_hit  = head.valid && (head.mac == req_ff.src_addr);
   assign evict_now = head.valid && (head_age > evict_ff)
                      && (nev_ff < EvictCountWidth'(MaxResults));
   assign tgt      = hit_ff ? hit_idx_ff : free_idx_ff;
   assign req_ready = (fsm_ff == FSM_IDLE);
   assign shift_en = step_en && ((fsm_ff == FSM_SCAN) || (fsm_ff == FSM_APPLY));

   always_comb begin
      fsm_in       = fsm_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      nev_in       = nev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      head_new     = head;

      case (fsm_ff)
         FSM_IDLE: begin
            if (req_valid && (req_data.req_type <= REQ_READ)) begin
               req_in    = req_data;
               fsm_in    = FSM_SCAN;
               cnt_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               pend_v_in = 1'b0;
               nev_in    = '0;
            end
         end
         FSM_SCAN: begin
            if (step_en) begin
               cnt_in = cnt_ff + 1'b1;
               if (req_ff.req_type == REQ_SWEEP) begin
                  if (evict_now) begin
                     head_new.valid = 1'b0;
                     head_new.state = EvictedState;
                     if (pend_v_ff) begin
                        rsp_in       = put_entry(pend_ff, ST_EVICTED, pend_idx_ff,
                                                 req_ff.now_ms, 1'b0);
                        rsp_valid_in = 1'b1;
                     end
                     pend_v_in   = 1'b1;
                     pend_in     = head_new;
                     pend_idx_in = cnt_ff;
                     nev_in      = nev_ff + 1'b1;
                  end
               end else if (req_ff.req_type == REQ_READ) begin
                  if (5'(cnt_ff) == req_ff.slot_index && 32'(cnt_ff) == 32'(req_ff.slot_index)) begin
                     pend_v_in   = 1'b1;
                     pend_in     = head;
                     pend_idx_in = cnt_ff;
                  end
               end else begin
                  if (mac_hit && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cnt_ff;
                  end
                  if (!head.valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = cnt_ff;
                  end
               end
               if (is_last) begin
                  cnt_in = '0;
                  if (req_ff.req_type <= REQ_DISCOVERY) begin
                     if (hit_in || free_in) begin
                        fsm_in = FSM_APPLY;
                     end else begin
                        rsp_in       = put_blank(ST_FULL, 5'd0);
                        rsp_valid_in = 1'b1;
                        fsm_in       = FSM_IDLE;
                     end
                  end else begin
                     fsm_in = FSM_FLUSH;
                  end
               end
            end
         end
         FSM_APPLY: begin
            if (step_en) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == tgt) begin
                  if (!hit_ff) begin
                     head_new.valid   = 1'b1;
                     head_new.mac     = req_ff.src_addr;
                     head_new.packets = '0;
                  end
                  head_new.seen_ms = req_ff.now_ms;
                  if (req_ff.req_type == REQ_SENSOR) begin
                     head_new.hops    = req_ff.gw_hops;
                     head_new.rssi    = req_ff.rssi;
                     head_new.peers   = req_ff.peer_num;
                     head_new.state   = req_ff.self_state;
                     head_new.packets = head_new.packets + 16'd1;
                  end else if (req_ff.req_type == REQ_HEARTBEAT) begin
                     head_new.rssi    = req_ff.rssi;
                     head_new.peers   = req_ff.peer_num;
                     head_new.state   = req_ff.self_state;
                     head_new.uptime  = req_ff.run_seconds;
                  end
                  rsp_in       = put_entry(head_new, hit_ff ? ST_UPDATED : ST_ADDED,
                                           cnt_ff, req_ff.now_ms, 1'b1);
                  rsp_valid_in = 1'b1;
               end
               if (is_last) begin
                  cnt_in = '0;
                  fsm_in = FSM_IDLE;
               end
            end
         end
         FSM_FLUSH: begin
            if (step_en) begin
               rsp_valid_in = 1'b1;
               fsm_in       = FSM_IDLE;
               if (req_ff.req_type == REQ_SWEEP) begin
                  rsp_in = pend_v_ff ? put_entry(pend_ff, ST_EVICTED, pend_idx_ff,
                                                 req_ff.now_ms, 1'b1)
                                     : put_blank(ST_NONE, 5'd0);
               end else if (pend_v_ff && pend_ff.valid) begin
                  rsp_in = put_entry(pend_ff,
                                     (pend_age > offline_ff) ? ST_OFFLINE :
                                     (pend_age > warn_ff) ? ST_WARNING : ST_ACTIVE,
                                     pend_idx_ff, req_ff.now_ms, 1'b1);
               end else begin
                  rsp_in = put_blank(ST_EMPTY, req_ff.slot_index);
               end
            end
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         nev_ff       <= '0;
      end else begin
         fsm_ff       <= fsm_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         pend_v_ff    <= pend_v_in;
         nev_ff       <= nev_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      pend_ff     <= pend_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A request of a known type always starts a rotation.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type <= REQ_READ)) |=> (fsm_ff == FSM_SCAN))
      else $error("request did not start a scan");

   // The ring position is at slot zero whenever the block is idle.
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == FSM_IDLE) |-> (cnt_ff == '0))
      else $error("ring left misaligned");

   // A table-full result carries slot zero.
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status_code == ST_FULL)) |-> (rsp_ff.found_slot == 5'd0))
      else $error("table full with a slot index");

   // The ring never turns while an undelivered item blocks the output.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !shift_en)
      else $error("ring turned under a stall");

endmodule
`default_nettype wire

[tb/tb_node_table_with_aging_core.sv]
`default_nettype none
module tb_node_table_with_aging_core;
   import nta_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The run is stopped here if the block stops making progress.
   localparam int CycleLimit = 1000000;
   // A report takes two rotations of the ring, so allow for that.
   localparam int SettleCycles = 100;
   localparam int NumSlots = 32;
   localparam int MacPoolSize = 40;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   node_table_with_aging_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Our own copy of the node table and of the three age thresholds.
   entry_type   node_tbl [NumSlots];
   logic [31:0] warn_limit;
   logic [31:0] offline_limit;
   logic [31:0] evict_limit;

   // Results that the block owes us, oldest first.
   rsp_type     owed_results[$];

   int          mismatch_count;
   int          cycle_count;
   int          items_sent;
   int          results_seen;
   int          evictions_seen;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   int          hold_left;
   logic [31:0] clock_ms;
   logic [47:0] mac_pool [MacPoolSize];

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // The receiver. A long hold-off, when one is requested, takes precedence
   // over the random idling so that the block fills up behind it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what,
               got, want);
      mismatch_count++;
   endtask

   // Every item that the block hands over is compared with the oldest result
   // still owed, field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (owed_results.size() == 0) begin
            $display("ERROR cycle %0d: result item arrived with none expected",
                     cycle_count);
            mismatch_count++;
         end else begin
            want = owed_results.pop_front();
            if (want.status_code == ST_EVICTED) begin
               evictions_seen++;
            end
            if (rsp_data.status_code !== want.status_code)
               report_mismatch("status_code", rsp_data.status_code, want.status_code);
            if (rsp_data.found_slot !== want.found_slot)
               report_mismatch("found_slot", rsp_data.found_slot, want.found_slot);
            if (rsp_data.entry_mac !== want.entry_mac)
               report_mismatch("entry_mac", rsp_data.entry_mac, want.entry_mac);
            if (rsp_data.entry_age_ms !== want.entry_age_ms)
               report_mismatch("entry_age_ms", rsp_data.entry_age_ms, want.entry_age_ms);
            if (rsp_data.entry_hops !== want.entry_hops)
               report_mismatch("entry_hops", rsp_data.entry_hops, want.entry_hops);
            if (rsp_data.entry_rssi !== want.entry_rssi)
               report_mismatch("entry_rssi", rsp_data.entry_rssi, want.entry_rssi);
            if (rsp_data.entry_peers !== want.entry_peers)
               report_mismatch("entry_peers", rsp_data.entry_peers, want.entry_peers);
            if (rsp_data.entry_state !== want.entry_state)
               report_mismatch("entry_state", rsp_data.entry_state, want.entry_state);
            if (rsp_data.entry_uptime !== want.entry_uptime)
               report_mismatch("entry_uptime", rsp_data.entry_uptime, want.entry_uptime);
            if (rsp_data.entry_packets !== want.entry_packets)
               report_mismatch("entry_packets", rsp_data.entry_packets,
                               want.entry_packets);
            if (rsp_data.last_result !== want.last_result)
               report_mismatch("last_result", rsp_data.last_result, want.last_result);
         end
      end
   end

   function automatic rsp_type blank_result(input logic [3:0] status,
                                            input logic [4:0] slot);
      rsp_type r;
      r = '0;
      r.status_code = status;
      r.found_slot = slot;
      r.last_result = 1'b1;
      return r;
   endfunction

   function automatic rsp_type entry_result(input logic [3:0] status, input int s,
                                            input logic [31:0] now, input logic last);
      rsp_type r;
      r.status_code = status;
      r.found_slot = s[4:0];
      r.entry_mac = node_tbl[s].mac;
      r.entry_age_ms = now - node_tbl[s].seen_ms;
      r.entry_hops = node_tbl[s].hops;
      r.entry_rssi = node_tbl[s].rssi;
      r.entry_peers = node_tbl[s].peers;
      r.entry_state = node_tbl[s].state;
      r.entry_uptime = node_tbl[s].uptime;
      r.entry_packets = node_tbl[s].packets;
      r.last_result = last;
      return r;
   endfunction

   // Works out what an accepted request does to the table and which result
   // items it owes, and queues them.
   function automatic void apply_request(input req_type_type q);
      int          hit;
      int          n;
      logic [3:0]  status;
      logic [31:0] age;
      rsp_type     r;
      hit = -1;
      n = 0;
      case (q.req_type)
         REQ_SENSOR, REQ_HEARTBEAT, REQ_DISCOVERY: begin
            for (int i = 0; i < NumSlots; i++) begin
               if (hit < 0 && node_tbl[i].valid && node_tbl[i].mac == q.src_addr) begin
                  hit = i;
               end
            end
            status = ST_UPDATED;
            if (hit < 0) begin
               for (int i = 0; i < NumSlots; i++) begin
                  if (hit < 0 && !node_tbl[i].valid) begin
                     hit = i;
                  end
               end
               if (hit < 0) begin
                  owed_results.push_back(blank_result(ST_FULL, 5'd0));
                  return;
               end
               // A new entry keeps whatever the slot held in the fields that
               // this report type does not write.
               node_tbl[hit].valid = 1'b1;
               node_tbl[hit].mac = q.src_addr;
               node_tbl[hit].packets = '0;
               status = ST_ADDED;
            end
            node_tbl[hit].seen_ms = q.now_ms;
            if (q.req_type == REQ_SENSOR) begin
               node_tbl[hit].hops = q.gw_hops;
               node_tbl[hit].rssi = q.rssi;
               node_tbl[hit].peers = q.peer_num;
               node_tbl[hit].state = q.self_state;
               node_tbl[hit].packets = node_tbl[hit].packets + 16'd1;
            end else if (q.req_type == REQ_HEARTBEAT) begin
               node_tbl[hit].rssi = q.rssi;
               node_tbl[hit].peers = q.peer_num;
               node_tbl[hit].state = q.self_state;
               node_tbl[hit].uptime = q.run_seconds;
            end
            owed_results.push_back(entry_result(status, hit, q.now_ms, 1'b1));
         end
         REQ_SWEEP: begin
            for (int i = 0; i < NumSlots; i++) begin
               if (node_tbl[i].valid && n < MaxResults
                   && (q.now_ms - node_tbl[i].seen_ms) > evict_limit) begin
                  node_tbl[i].valid = 1'b0;
                  node_tbl[i].state = EvictedState;
                  owed_results.push_back(entry_result(ST_EVICTED, i, q.now_ms, 1'b0));
                  n++;
               end
            end
            if (n == 0) begin
               owed_results.push_back(blank_result(ST_NONE, 5'd0));
            end else begin
               r = owed_results.pop_back();
               r.last_result = 1'b1;
               owed_results.push_back(r);
            end
         end
         REQ_READ: begin
            if (!node_tbl[q.slot_index].valid) begin
               owed_results.push_back(blank_result(ST_EMPTY, q.slot_index));
            end else begin
               age = q.now_ms - node_tbl[q.slot_index].seen_ms;
               if (age > offline_limit) status = ST_OFFLINE;
               else if (age > warn_limit) status = ST_WARNING;
               else status = ST_ACTIVE;
               owed_results.push_back(entry_result(status, q.slot_index, q.now_ms, 1'b1));
            end
         end
         default: begin
            // Unused request codes are swallowed without any result.
         end
      endcase
   endfunction

   // Offers one item and holds it until the block takes it, then idles at
   // random. The valid is only lowered while idling, so it is never lowered
   // and raised in the same step.
   task automatic send_item(input req_type_type q);
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(q);
      items_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Builds a request with every other field random.
   function automatic req_type_type make_request(input logic [2:0] kind,
                                                 input logic [31:0] now,
                                                 input logic [47:0] mac);
      req_type_type q;
      q.req_type = kind;
      q.now_ms = now;
      q.src_addr = mac;
      q.gw_hops = 8'($urandom_range(255));
      q.rssi = 8'($urandom_range(255));
      q.peer_num = 8'($urandom_range(255));
      q.self_state = 8'($urandom_range(255));
      q.run_seconds = $urandom;
      q.slot_index = 5'($urandom_range(31));
      return q;
   endfunction

   // Waits until every owed result has come and the block has had time to
   // finish any request that owes nothing.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_WARN:    warn_limit = value;
         REG_OFFLINE: offline_limit = value;
         REG_EVICT:   evict_limit = value;
         default:     ;
      endcase
      @(posedge clock);
      // The address is still on the port, so the new value reads back here.
      if (csr_prdata !== value) report_mismatch("register read-back", csr_prdata, value);
      if (csr_pready !== 1'b1) report_mismatch("pready", csr_pready, 1'b1);
   endtask

   task automatic set_thresholds(input logic [31:0] w, input logic [31:0] o,
                                 input logic [31:0] e);
      drain();
      write_threshold(REG_WARN, w);
      write_threshold(REG_OFFLINE, o);
      write_threshold(REG_EVICT, e);
   endtask

   // Directed reports: address extremes, each report type, field extremes,
   // hits and misses, reads of valid and empty slots, a sweep with nothing
   // to evict and the unused request codes.
   task automatic test_reports();
      req_type_type q;
      q = make_request(REQ_SENSOR, 32'd1000, 48'h0);
      q.gw_hops = 8'hFF;
      q.rssi = -8'sd128;
      q.peer_num = 8'h00;
      q.self_state = 8'hFF;
      send_item(q);
      q = make_request(REQ_SENSOR, 32'd2000, 48'hFFFF_FFFF_FFFF);
      q.gw_hops = 8'h00;
      q.rssi = 8'sd127;
      q.peer_num = 8'hFF;
      q.self_state = 8'h00;
      send_item(q);
      q = make_request(REQ_HEARTBEAT, 32'd3000, 48'h0);
      q.run_seconds = 32'hFFFF_FFFF;
      send_item(q);
      send_item(make_request(REQ_SENSOR, 32'd3500, 48'h0));
      send_item(make_request(REQ_DISCOVERY, 32'd4000, 48'h1234_5678_9ABC));
      send_item(make_request(REQ_HEARTBEAT, 32'd4100, 48'hAAAA_5555_AAAA));
      send_item(make_request(REQ_DISCOVERY, 32'd4200, 48'h0));
      for (int s = 0; s < 5; s++) begin
         q = make_request(REQ_READ, 32'd20000 + s * 8000, 48'h0);
         q.slot_index = 5'(s);
         send_item(q);
      end
      q = make_request(REQ_READ, 32'hFFFF_FFFF, 48'h0);
      q.slot_index = 5'd31;
      send_item(q);
      send_item(make_request(REQ_SWEEP, 32'd5000, 48'h0));
      send_item(make_request(3'd5, 32'd5000, 48'h0));
      send_item(make_request(3'd6, 32'd5000, 48'h0));
      send_item(make_request(3'd7, 32'd5000, 48'h0));
      send_item(make_request(REQ_SENSOR, 32'd5100, 48'h0));
   endtask

   // Fills every slot, offers more nodes than there is room for, then sweeps
   // at the eviction age of the new nodes, which keeps them, and just after it.
   task automatic test_full_table();
      req_type_type q;
      for (int i = 0; i < NumSlots + 1; i++) begin
         send_item(make_request(REQ_DISCOVERY, 32'd10000, 48'h5000_0000_0000 + i));
      end
      q = make_request(REQ_READ, 32'd10000, 48'h0);
      q.slot_index = 5'd31;
      send_item(q);
      send_item(make_request(REQ_SWEEP, 32'd10000 + evict_limit, 48'h0));
      send_item(make_request(REQ_SWEEP, 32'd10001 + evict_limit, 48'h0));
      send_item(make_request(REQ_SWEEP, 32'd10002 + evict_limit, 48'h0));
      // A new node now lands on slot 0 with the evicted slot's old fields.
      send_item(make_request(REQ_DISCOVERY, 32'd20000, 48'h7777_0000_0001));
   endtask

   // Threshold extremes: classes across zero and all-ones limits, and a
   // sweep with a zero eviction age, including across the time wrap.
   task automatic test_thresholds();
      req_type_type q;
      set_thresholds(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(make_request(REQ_SENSOR, 32'hFFFF_FFF0, 48'h0000_0000_00A1));
      q = make_request(REQ_READ, 32'hFFFF_FFF0, 48'h0);
      q.slot_index = 5'd1;
      send_item(q);
      q.now_ms = 32'h0000_0010;
      send_item(q);
      send_item(make_request(REQ_SWEEP, 32'hFFFF_FFEF, 48'h0));
      set_thresholds(32'hFFFF_FFFF, 32'd0, 32'd0);
      q.now_ms = 32'h0000_0020;
      send_item(q);
      send_item(make_request(REQ_SWEEP, 32'hFFFF_FFF0, 48'h0));
      send_item(make_request(REQ_SWEEP, 32'h0000_0001, 48'h0));
   endtask

   // Mostly reports from a small pool of nodes so that hits, insertions,
   // a full table and evictions all happen, with reads and sweeps between.
   task automatic test_random(input int count);
      int          pick;
      logic [2:0]  kind;
      logic [47:0] mac;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 30) kind = REQ_SENSOR;
         else if (pick < 50) kind = REQ_HEARTBEAT;
         else if (pick < 62) kind = REQ_DISCOVERY;
         else if (pick < 74) kind = REQ_SWEEP;
         else if (pick < 96) kind = REQ_READ;
         else kind = 3'(5 + $urandom_range(2));
         if ($urandom_range(49) == 0) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(12000);
         if ($urandom_range(9) == 0) mac = 48'({$urandom, $urandom});
         else mac = mac_pool[$urandom_range(MacPoolSize - 1)];
         send_item(make_request(kind, clock_ms, mac));
      end
   endtask

   // The receiver holds off for a long stretch while sensor reports keep
   // coming, so the block fills and stalls its input. Afterwards the sender
   // waits for every owed result before carrying on.
   task automatic test_backpressure();
      hold_left <= 400;
      @(posedge clock);
      for (int n = 0; n < 8; n++) begin
         clock_ms = clock_ms + 100;
         send_item(make_request(REQ_SENSOR, clock_ms, mac_pool[n]));
      end
      send_item(make_request(REQ_SWEEP, clock_ms + 32'h8000_0000, 48'h0));
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      mismatch_count = 0;
      cycle_count = 0;
      items_sent = 0;
      results_seen = 0;
      evictions_seen = 0;
      hold_left = 0;
      sender_idle_pct = 20;
      receiver_idle_pct = 85;
      clock_ms = 32'd100000;
      warn_limit = 32'd15000;
      offline_limit = 32'd30000;
      evict_limit = 32'd60000;
      for (int i = 0; i < NumSlots; i++) node_tbl[i] = '0;
      for (int i = 0; i < MacPoolSize; i++) mac_pool[i] = 48'({$urandom, $urandom});
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reports();
      test_full_table();
      test_thresholds();

      // Random traffic in three idling regimes, with a fresh set of
      // thresholds for each, the defaults among them.
      set_thresholds(32'd15000, 32'd30000, 32'd60000);
      test_random(120);
      test_backpressure();
      sender_idle_pct = 85;
      receiver_idle_pct = 20;
      set_thresholds(32'd4000, 32'd9000, 32'd20000);
      test_random(120);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_thresholds(32'd20000, 32'd10000, 32'd40000);
      test_random(120);

      drain();
      $display("Sent %0d request items and checked %0d result items.", items_sent,
               results_seen);
      $display("Evictions seen: %0d; thresholds exercised at zero, all-ones and between.",
               evictions_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
src/nta_pkg.sv
src/nta_cell.sv
src/node_table_with_aging_core.sv
tb/tb_node_table_with_aging_core.sv
